// ===== rtl/finite_automaton_string_matcher_top_macros.svh =====
// Assertion helpers for the string matcher checker.
`ifndef FINITE_AUTOMATON_STRING_MATCHER_TOP_MACROS_SVH
`define FINITE_AUTOMATON_STRING_MATCHER_TOP_MACROS_SVH

// Clocked assertion, disabled while reset is high.
`define FASM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define FASM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/fasm_pkg.sv =====
package fasm_pkg;

  localparam int MAX_PATTERN = 32;
  localparam int PAT_IDX_W   = $clog2(MAX_PATTERN);
  localparam int LEN_W       = 6;
  localparam int INDEX_BITS  = 32;
  localparam int COUNT_W     = 32;
  localparam int BYTE_W      = 8;
  localparam int CFG_W       = 64;
  localparam int PAT_REGS    = 4;
  localparam int CFG_IDX_W   = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT_0_7   = 3'd0,
    REG_PAT_8_15  = 3'd1,
    REG_PAT_16_23 = 3'd2,
    REG_PAT_24_31 = 3'd3,
    REG_PAT_LEN   = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic              advance;
    logic [BYTE_W-1:0] text_byte;
  } cell_ctl_t;

endpackage

// ===== rtl/fasm_cell.sv =====
module fasm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  fasm_pkg::cell_ctl_t        ctl,
  input  logic                       enable,
  input  logic [fasm_pkg::BYTE_W-1:0] pat_byte,
  input  logic                       prev,
  output logic                       active,
  output logic                       active_next
);
  import fasm_pkg::*;

  assign active_next = prev & enable & (pat_byte == ctl.text_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (ctl.advance) begin
      active <= active_next;
    end
  end

endmodule

// ===== rtl/finite_automaton_string_matcher_top.sv =====
// A result is registered as its text item is accepted and is presented in the next cycle.
// Throughput: one item per cycle while results are taken; a chain of 32 match cells updates in one step.
// A waiting result stalls input only while the downstream side holds ready low.
// Reset (rst, synchronous) clears pattern, length, prefixes, position and count.
module finite_automaton_string_matcher_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_we,
  input  logic [fasm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [fasm_pkg::CFG_W-1:0]    cfg_data,
  input  logic                          text_valid,
  output logic                          text_ready,
  input  logic [fasm_pkg::BYTE_W-1:0]   text_byte,
  input  logic                          text_start,
  output logic                          match_valid,
  input  logic                          match_ready,
  output logic                          match_found,
  output logic [fasm_pkg::INDEX_BITS-1:0] match_start,
  output logic [fasm_pkg::COUNT_W-1:0]  match_total,
  output logic [fasm_pkg::LEN_W-1:0]    prefix_length
);
  import fasm_pkg::*;

  logic [PAT_REGS-1:0][CFG_W-1:0]     pat_regs;
  logic [LEN_W-1:0]                   pat_len;
  logic [MAX_PATTERN-1:0][BYTE_W-1:0] pat_bytes;
  logic [LEN_W-1:0]                   len_eff;
  logic [PAT_IDX_W-1:0]               len_m1;
  logic [MAX_PATTERN-1:0]             enable;
  logic [MAX_PATTERN-1:0]             prev;
  logic [MAX_PATTERN-1:0]             active;
  logic [MAX_PATTERN-1:0]             active_next;
  logic [INDEX_BITS-1:0]              text_position;
  logic [INDEX_BITS-1:0]              pos_eff;
  logic [COUNT_W-1:0]                 match_counter;
  logic [COUNT_W-1:0]                 cnt_eff;
  logic [COUNT_W-1:0]                 match_counter_next;
  logic [LEN_W-1:0]                   longest;
  logic                               found;
  logic                               accept;
  cell_ctl_t                          ctl;

  assign text_ready = !match_valid || match_ready;
  assign accept     = text_valid && text_ready;
  assign pat_bytes  = pat_regs;
  assign len_eff    = (pat_len > LEN_W'(MAX_PATTERN)) ? LEN_W'(MAX_PATTERN) : pat_len;
  assign len_m1     = PAT_IDX_W'(len_eff - LEN_W'(1));

  assign ctl.advance   = accept;
  assign ctl.text_byte = text_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      pat_regs <= '0;
      pat_len  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_PAT_0_7:   pat_regs[0] <= cfg_data;
        REG_PAT_8_15:  pat_regs[1] <= cfg_data;
        REG_PAT_16_23: pat_regs[2] <= cfg_data;
        REG_PAT_24_31: pat_regs[3] <= cfg_data;
        REG_PAT_LEN:   pat_len     <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    assign enable[k] = LEN_W'(k) < len_eff;
    if (k == 0) begin : g_head
      assign prev[k] = 1'b1;
    end else begin : g_link
      assign prev[k] = active[k-1] & ~text_start;
    end
    fasm_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctl         (ctl),
      .enable      (enable[k]),
      .pat_byte    (pat_bytes[k]),
      .prev        (prev[k]),
      .active      (active[k]),
      .active_next (active_next[k])
    );
  end

  always_comb begin
    longest = '0;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (active_next[k]) begin
        longest = LEN_W'(k + 1);
      end
    end
  end

  assign pos_eff = text_start ? '0 : text_position;
  assign cnt_eff = text_start ? '0 : match_counter;
  assign found   = (len_eff != '0) && active_next[len_m1];
  assign match_counter_next = (found && (cnt_eff != '1)) ? cnt_eff + COUNT_W'(1) : cnt_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      text_position <= '0;
      match_counter <= '0;
      match_valid   <= 1'b0;
    end else begin
      if (accept) begin
        text_position <= pos_eff + INDEX_BITS'(1);
        match_counter <= match_counter_next;
        match_valid   <= 1'b1;
      end else if (match_ready) begin
        match_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      match_found   <= found;
      match_start   <= found ? pos_eff - INDEX_BITS'(len_m1) : '0;
      match_total   <= match_counter_next;
      prefix_length <= longest;
    end
  end

endmodule

// ===== rtl/fasm_chk.sv =====
`include "finite_automaton_string_matcher_top_macros.svh"

module fasm_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          match_valid,
  input logic                          match_ready,
  input logic                          match_found,
  input logic [fasm_pkg::INDEX_BITS-1:0] match_start,
  input logic [fasm_pkg::COUNT_W-1:0]  match_total,
  input logic [fasm_pkg::LEN_W-1:0]    prefix_length
);
  import fasm_pkg::*;

  `FASM_ASSERT_ALWAYS(a_reset_idle, clk, rst |=> !match_valid, "result valid after reset")
  `FASM_ASSERT(a_start_zero, clk, rst, match_valid && !match_found |-> match_start == '0, "start index set without a match")
  `FASM_ASSERT(a_found_state, clk, rst, match_valid && match_found |-> prefix_length != '0 && match_total != '0, "match with empty prefix or zero count")
  `FASM_ASSERT(a_prefix_range, clk, rst, match_valid |-> prefix_length <= LEN_W'(MAX_PATTERN), "prefix length beyond pattern limit")
  `FASM_ASSERT(a_hold, clk, rst, match_valid && !match_ready |=> match_valid && $stable(match_total) && $stable(match_start), "stalled item changed")

endmodule

bind finite_automaton_string_matcher_top fasm_chk u_fasm_chk (.*);
